### design/bda_pkg.sv
// Shared types and constants for the button debounce and auto-repeat block.
`default_nettype none

package bda_pkg;

    localparam int NUM_BUTTONS    = 3;
    localparam int RAW_PIN_COUNT  = 3;
    localparam int TIMER_W        = 16;
    localparam int INDEX_W        = 2;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 16;

    localparam logic [TIMER_W-1:0] LONG_PRESS_RESET = 16'd100;
    localparam logic [TIMER_W-1:0] REPEAT_RESET     = 16'd25;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESSED_LEVEL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT        = 2'd2;

    // Input commands
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_POLL = 1'b1;

    typedef struct packed {
        logic                     cmd;
        logic [RAW_PIN_COUNT-1:0] raw_pins;
    } bda_in_t;

    typedef struct packed {
        logic               press_found;
        logic [INDEX_W-1:0] button_index;
    } bda_out_t;

    typedef struct packed {
        logic               pressed_level;
        logic [TIMER_W-1:0] long_press_ticks;
        logic [TIMER_W-1:0] repeat_ticks;
    } bda_cfg_t;

    typedef struct packed {
        logic tick;
        logic level;
        logic clear;
    } bda_ctl_t;

endpackage

`default_nettype wire

### design/bda_button.sv
// Per-button three-sample debounce, pending flag and auto-repeat timer.
`default_nettype none

module bda_button
    import bda_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire bda_cfg_t cfg,
    input  wire bda_ctl_t ctl,
    output logic          pending
);

    logic               middle_reg, middle_next;
    logic               newest_reg, newest_next;
    logic               stable_reg, stable_next;
    logic               pending_reg, pending_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic               agree;

    // oldest sample is never read after the shift, so only two are kept
    assign agree = (middle_reg == newest_reg) && (newest_reg == ctl.level);

    always_comb begin
        middle_next  = middle_reg;
        newest_next  = newest_reg;
        stable_next  = stable_reg;
        pending_next = pending_reg;
        timer_next   = timer_reg;
        if (ctl.tick) begin
            middle_next = newest_reg;
            newest_next = ctl.level;
            if (agree) begin
                if (stable_reg != ctl.level) begin
                    stable_next = ctl.level;
                    if (ctl.level == cfg.pressed_level) begin
                        pending_next = 1'b1;
                        timer_next   = cfg.long_press_ticks;
                    end
                end else if (timer_reg <= TIMER_W'(1)) begin
                    if (stable_reg == cfg.pressed_level) begin
                        pending_next = 1'b1;
                    end
                    timer_next = cfg.repeat_ticks;
                end else begin
                    timer_next = timer_reg - TIMER_W'(1);
                end
            end
        end else if (ctl.clear) begin
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            middle_reg  <= 1'b0;
            newest_reg  <= 1'b0;
            stable_reg  <= 1'b0;
            pending_reg <= 1'b0;
            timer_reg   <= LONG_PRESS_RESET;
        end else begin
            middle_reg  <= middle_next;
            newest_reg  <= newest_next;
            stable_reg  <= stable_next;
            pending_reg <= pending_next;
            timer_reg   <= timer_next;
        end
    end

    assign pending = pending_reg;

endmodule

`default_nettype wire

### design/button_debounce_autorepeat_top.sv
// Top level: config registers, button array, poll encoder and result register.
// An accepted item's result is registered into the output register.
// Throughput: one item per cycle while s_ready is high; the per-button state updates in one pass.
// s_ready stays high while the result register is empty or being taken.
// Reset (aresetn low, synchronous) clears all samples, levels and pending flags,
// loads timers with 100, and restores pressed_level 0, long 100, repeat 25.
`default_nettype none

module button_debounce_autorepeat_top
    import bda_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire bda_in_t                s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output bda_out_t                    m_data
);

    bda_cfg_t                 cfg_reg;
    logic                     m_valid_reg;
    bda_out_t                 m_data_reg;
    bda_out_t                 result;
    logic                     accept;
    logic                     do_tick;
    logic                     do_poll;
    logic [NUM_BUTTONS-1:0]   level;
    logic [NUM_BUTTONS-1:0]   pending;
    logic [NUM_BUTTONS-1:0]   clear_sel;
    bda_ctl_t                 ctl [NUM_BUTTONS];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign do_tick = accept && (s_data.cmd == CMD_TICK);
    assign do_poll = accept && (s_data.cmd == CMD_POLL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pressed_level    <= 1'b0;
            cfg_reg.long_press_ticks <= LONG_PRESS_RESET;
            cfg_reg.repeat_ticks     <= REPEAT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PRESSED_LEVEL: cfg_reg.pressed_level    <= cfg_wdata[0];
                CFG_LONG_PRESS:    cfg_reg.long_press_ticks <= cfg_wdata[TIMER_W-1:0];
                CFG_REPEAT:        cfg_reg.repeat_ticks     <= cfg_wdata[TIMER_W-1:0];
                default:           ;
            endcase
        end
    end

    for (genvar gi = 0; gi < NUM_BUTTONS; gi++) begin : g_btn
        // buttons past the raw pin field see level 0
        if (gi < RAW_PIN_COUNT) begin : g_pin
            assign level[gi] = s_data.raw_pins[gi];
        end else begin : g_nopin
            assign level[gi] = 1'b0;
        end

        assign ctl[gi] = '{tick: do_tick, level: level[gi], clear: do_poll && clear_sel[gi]};

        bda_button u_button (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cfg     (cfg_reg),
            .ctl     (ctl[gi]),
            .pending (pending[gi])
        );
    end

    // lowest pending button wins
    always_comb begin
        clear_sel           = '0;
        result.press_found  = 1'b0;
        result.button_index = '0;
        for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
            if (pending[i]) begin
                clear_sel           = '0;
                clear_sel[i]        = 1'b1;
                result.press_found  = 1'b1;
                result.button_index = i[INDEX_W-1:0];
            end
        end
        if (s_data.cmd == CMD_TICK) begin
            result.press_found  = 1'b0;
            result.button_index = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
